FILE: hw/rtl/rmv_pkg.sv
// rmv_pkg: shared types and constants for the running mean / variance core.
// No dependencies; used by running_mean_variance_core.
package rmv_pkg;

	localparam int WORD_W = 64;   // internal arithmetic width, wraps as 64-bit
	localparam int HALF_W = 32;   // multiplier operand width
	localparam int OUT_W  = 32;   // width of count and mean result fields

	// restoring divider: one quotient bit per cycle
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// partial products of the two 64x64 (mod 2^64) multiplications
	localparam int MUL_ISSUES = 6;
	localparam int MUL_CNT_W  = $clog2(MUL_ISSUES + 1);

	localparam logic [MUL_CNT_W-1:0] MUL_AB_LL  = MUL_CNT_W'(0);
	localparam logic [MUL_CNT_W-1:0] MUL_AB_LH  = MUL_CNT_W'(1);
	localparam logic [MUL_CNT_W-1:0] MUL_AB_HL  = MUL_CNT_W'(2);
	localparam logic [MUL_CNT_W-1:0] MUL_CD_LL  = MUL_CNT_W'(3);
	localparam logic [MUL_CNT_W-1:0] MUL_CD_LH  = MUL_CNT_W'(4);
	localparam logic [MUL_CNT_W-1:0] MUL_CD_HL  = MUL_CNT_W'(5);
	localparam logic [MUL_CNT_W-1:0] MUL_FLUSH  = MUL_CNT_W'(6);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_LOAD_A = 9'b000000010,
		S_DIV_A  = 9'b000000100,
		S_MEAN   = 9'b000001000,
		S_DEV    = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_LOAD_B = 9'b001000000,
		S_DIV_B  = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

endpackage

FILE: hw/rtl/running_mean_variance_core.sv
// running_mean_variance_core: online integer mean and population variance.
// Uses rmv_pkg for constants and the sequencer state type.
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | sample
//  output   | out_valid / out_ready| sample_count, running_mean, running_variance
//
// First sample after reset: accept, then write back.
// Later samples: two passes through the shared one-bit-per-cycle divider
// (mean, then variance) with a pass through the shared 32x32 multiplier
// and sequencing steps between them, then write back.
// arst_n clears count, mean, variance and the sequencer.
// A finished word sits in the output register; the core takes the next
// sample while it waits, and stalls at write back only if it is still held.
module running_mean_variance_core #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic        [SAMPLE_WIDTH-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rmv_pkg::OUT_W-1:0]      sample_count,
	output logic signed [rmv_pkg::OUT_W-1:0] running_mean,
	output logic signed [rmv_pkg::WORD_W-1:0] running_variance
);

	localparam int W  = rmv_pkg::WORD_W;
	localparam int H  = rmv_pkg::HALF_W;
	localparam int CW = COUNT_WIDTH;
	localparam int SW = SAMPLE_WIDTH;

	rmv_pkg::state_t state_q;

	// architectural state
	logic [CW-1:0] count_q;
	logic [SW-1:0] mean_q;
	logic [W-1:0]  var_q;

	// per-item working registers
	logic          first_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] nm1_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  dev_old_q;
	logic [W-1:0]  new_mean_q;
	logic [W-1:0]  dev_new_q;
	logic [W-1:0]  acc_q;

	// shared divider
	logic [W-1:0]                 div_quo_q;
	logic [CW-1:0]                div_rem_q;
	logic                         div_neg_q;
	logic [rmv_pkg::DIV_CNT_W-1:0] div_cnt_q;

	// shared multiplier
	logic [rmv_pkg::MUL_CNT_W-1:0] mul_cnt_q;
	logic [2*H-1:0]                mul_p_s1;
	logic                          mul_sh_s1;
	logic                          mul_vld_s1;

	logic                          out_valid_q;
	logic [rmv_pkg::OUT_W-1:0]     cnt_out_q;
	logic [rmv_pkg::OUT_W-1:0]     mean_out_q;
	logic [W-1:0]                  var_out_q;

	logic [W-1:0]  x_ext;
	logic [W-1:0]  mean_ext;
	logic [W-1:0]  nm_trunc_ext;
	logic [W-1:0]  nm1_ext;
	logic [W-1:0]  n_ext;
	logic          cnt_sat;
	logic          accept;
	logic          out_free;

	generate
		if (SW == W) begin : g_full
			assign x_ext        = sample;
			assign mean_ext     = mean_q;
			assign nm_trunc_ext = new_mean_q;
		end else begin : g_ext
			assign x_ext        = {{(W-SW){sample[SW-1]}}, sample};
			assign mean_ext     = {{(W-SW){mean_q[SW-1]}}, mean_q};
			assign nm_trunc_ext = {{(W-SW){new_mean_q[SW-1]}}, new_mean_q[SW-1:0]};
		end
	endgenerate

	assign nm1_ext  = {{(W-CW){1'b0}}, nm1_q};
	assign n_ext    = {{(W-CW){1'b0}}, n_q};
	assign cnt_sat  = (count_q == {CW{1'b1}});
	assign in_ready = (state_q == rmv_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign sample_count     = cnt_out_q;
	assign running_mean     = mean_out_q;
	assign running_variance = var_out_q;

	// divider step: shift in next dividend bit, subtract if it fits
	logic [CW:0]   rem_sh;
	logic [CW+1:0] rem_diff;
	logic          rem_fits;
	logic [W-1:0]  div_src;
	logic [W-1:0]  div_abs;
	logic [W-1:0]  quo_signed;

	assign rem_sh   = {div_rem_q, div_quo_q[W-1]};
	assign rem_diff = {1'b0, rem_sh} - {2'b00, n_q};
	assign rem_fits = !rem_diff[CW+1];
	assign div_src  = (state_q == rmv_pkg::S_LOAD_B) ? acc_q : dev_old_q;
	assign div_abs  = div_src[W-1] ? (~div_src + W'(1)) : div_src;
	assign quo_signed = div_neg_q ? (~div_quo_q + W'(1)) : div_quo_q;

	// multiplier operand select: A=n-1, B=variance, C=dev_old, D=dev_new
	logic [H-1:0] mul_a;
	logic [H-1:0] mul_b;
	logic         mul_sh;

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_sh = 1'b0;
		case (mul_cnt_q)
			rmv_pkg::MUL_AB_LL: begin
				mul_a = nm1_ext[H-1:0];
				mul_b = var_q[H-1:0];
			end
			rmv_pkg::MUL_AB_LH: begin
				mul_a  = nm1_ext[H-1:0];
				mul_b  = var_q[W-1:H];
				mul_sh = 1'b1;
			end
			rmv_pkg::MUL_AB_HL: begin
				mul_a  = nm1_ext[W-1:H];
				mul_b  = var_q[H-1:0];
				mul_sh = 1'b1;
			end
			rmv_pkg::MUL_CD_LL: begin
				mul_a = dev_old_q[H-1:0];
				mul_b = dev_new_q[H-1:0];
			end
			rmv_pkg::MUL_CD_LH: begin
				mul_a  = dev_old_q[H-1:0];
				mul_b  = dev_new_q[W-1:H];
				mul_sh = 1'b1;
			end
			rmv_pkg::MUL_CD_HL: begin
				mul_a  = dev_old_q[W-1:H];
				mul_b  = dev_new_q[H-1:0];
				mul_sh = 1'b1;
			end
			default: begin
				mul_a  = '0;
				mul_b  = '0;
				mul_sh = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmv_pkg::S_IDLE;
			count_q     <= '0;
			mean_q      <= '0;
			var_q       <= '0;
			first_q     <= 1'b0;
			div_cnt_q   <= '0;
			mul_cnt_q   <= '0;
			mul_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == rmv_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			mul_vld_s1 <= (state_q == rmv_pkg::S_MUL) && (mul_cnt_q != rmv_pkg::MUL_FLUSH);
			unique case (state_q)
				rmv_pkg::S_IDLE: begin
					if (accept) begin
						count_q <= cnt_sat ? count_q : count_q + CW'(1);
						first_q <= (count_q == '0);
						state_q <= (count_q == '0) ? rmv_pkg::S_DONE : rmv_pkg::S_LOAD_A;
					end
				end
				rmv_pkg::S_LOAD_A: begin
					div_cnt_q <= '0;
					state_q   <= rmv_pkg::S_DIV_A;
				end
				rmv_pkg::S_DIV_A: begin
					div_cnt_q <= div_cnt_q + rmv_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == rmv_pkg::DIV_CNT_W'(rmv_pkg::DIV_STEPS - 1)) begin
						state_q <= rmv_pkg::S_MEAN;
					end
				end
				rmv_pkg::S_MEAN: begin
					state_q <= rmv_pkg::S_DEV;
				end
				rmv_pkg::S_DEV: begin
					mul_cnt_q <= '0;
					state_q   <= rmv_pkg::S_MUL;
				end
				rmv_pkg::S_MUL: begin
					if (mul_cnt_q == rmv_pkg::MUL_FLUSH) begin
						state_q <= rmv_pkg::S_LOAD_B;
					end else begin
						mul_cnt_q  <= mul_cnt_q + rmv_pkg::MUL_CNT_W'(1);
					end
				end
				rmv_pkg::S_LOAD_B: begin
					div_cnt_q <= '0;
					state_q   <= rmv_pkg::S_DIV_B;
				end
				rmv_pkg::S_DIV_B: begin
					div_cnt_q <= div_cnt_q + rmv_pkg::DIV_CNT_W'(1);
					if (div_cnt_q == rmv_pkg::DIV_CNT_W'(rmv_pkg::DIV_STEPS - 1)) begin
						state_q <= rmv_pkg::S_DONE;
					end
				end
				rmv_pkg::S_DONE: begin
					if (out_free) begin
						if (first_q) begin
							mean_q <= x_q[SW-1:0];
							var_q  <= '0;
						end else begin
							mean_q <= new_mean_q[SW-1:0];
							var_q  <= quo_signed;
						end
						state_q     <= rmv_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= rmv_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= x_ext;
			dev_old_q <= x_ext - mean_ext;
			n_q       <= cnt_sat ? count_q : count_q + CW'(1);
			nm1_q     <= cnt_sat ? count_q - CW'(1) : count_q;
		end
		if (state_q == rmv_pkg::S_LOAD_A || state_q == rmv_pkg::S_LOAD_B) begin
			div_quo_q <= div_abs;
			div_neg_q <= div_src[W-1];
			div_rem_q <= '0;
		end
		if (state_q == rmv_pkg::S_DIV_A || state_q == rmv_pkg::S_DIV_B) begin
			div_quo_q <= {div_quo_q[W-2:0], rem_fits};
			div_rem_q <= rem_fits ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
		end
		if (state_q == rmv_pkg::S_MEAN) begin
			new_mean_q <= div_neg_q ? (mean_ext - div_quo_q) : (mean_ext + div_quo_q);
		end
		if (state_q == rmv_pkg::S_DEV) begin
			dev_new_q <= x_q - new_mean_q;
			acc_q     <= '0;
		end
		if (state_q == rmv_pkg::S_MUL) begin
			mul_p_s1  <= mul_a * mul_b;
			mul_sh_s1 <= mul_sh;
		end
		if (mul_vld_s1) begin
			acc_q <= acc_q + (mul_sh_s1 ? {mul_p_s1[H-1:0], {H{1'b0}}} : mul_p_s1);
		end
		if (state_q == rmv_pkg::S_DONE && out_free) begin
			cnt_out_q <= n_ext[rmv_pkg::OUT_W-1:0];
			if (first_q) begin
				mean_out_q <= x_q[rmv_pkg::OUT_W-1:0];
				var_out_q  <= '0;
			end else begin
				mean_out_q <= nm_trunc_ext[rmv_pkg::OUT_W-1:0];
				var_out_q  <= quo_signed;
			end
		end
	end

	// a new word appears only on write back
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rmv_pkg::S_DONE))
		else $error("output word loaded outside write back");

	// divider remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmv_pkg::S_MEAN || state_q == rmv_pkg::S_DONE) && !first_q
		|-> (div_rem_q < n_q))
		else $error("divider remainder not below count");

	// sample count never goes down
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q >= $past(count_q)))
		else $error("sample count decreased");

	// after the last divide step of the mean the sequencer moves on
	a_div_a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rmv_pkg::S_DIV_A) &&
		(div_cnt_q == rmv_pkg::DIV_CNT_W'(rmv_pkg::DIV_STEPS - 1))
		|=> (state_q == rmv_pkg::S_MEAN))
		else $error("mean divide did not finish in time");

endmodule

FILE: tb/running_mean_variance_monitor.sv
// running_mean_variance_monitor: watches both channels of the core, predicts
// each result word with its own running-statistics model and compares them.
// Depends on rmv_pkg for the result field widths.
module running_mean_variance_monitor #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [SAMPLE_WIDTH-1:0]           sample,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [rmv_pkg::OUT_W-1:0]         sample_count,
	input  logic signed [rmv_pkg::OUT_W-1:0]  running_mean,
	input  logic signed [rmv_pkg::WORD_W-1:0] running_variance,
	output int                                errors,
	output int                                words_due
);

	localparam logic [63:0] COUNT_MAX = (COUNT_WIDTH >= 64) ? '1 :
		(64'd1 << COUNT_WIDTH) - 64'd1;

	typedef struct packed {
		logic [31:0] count;
		logic [31:0] mean;
		logic [63:0] variance;
	} stats_t;

	stats_t      stats_due_q[$];
	logic [63:0] tally;
	logic [63:0] mean_acc;
	logic [63:0] var_acc;
	int          mismatches;
	int          words_seen;

	// signed 64-bit divide, truncating toward zero
	function automatic logic [63:0] trunc_div(input logic [63:0] num, input logic [63:0] den);
		longint a;
		longint b;
		a = num;
		b = den;
		return a / b;
	endfunction

	task automatic fold_sample(input logic [SAMPLE_WIDTH-1:0] s, output stats_t st);
		logic [63:0] x;
		logic [63:0] dev_old;
		logic [63:0] new_mean;
		logic [63:0] dev_new;
		logic [63:0] total;
		x = 64'($signed(s));
		if (tally < COUNT_MAX) begin
			tally = tally + 64'd1;
		end
		if (tally == 64'd1) begin
			mean_acc = x;
			var_acc  = '0;
		end else begin
			dev_old  = x - mean_acc;
			new_mean = mean_acc + trunc_div(dev_old, tally);
			dev_new  = x - new_mean;
			total    = (tally - 64'd1) * var_acc + dev_old * dev_new;
			mean_acc = 64'($signed(new_mean[SAMPLE_WIDTH-1:0]));
			var_acc  = trunc_div(total, tally);
		end
		st.count    = tally[31:0];
		st.mean     = mean_acc[31:0];
		st.variance = var_acc;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stats_t want;
		stats_t got;
		if (!arst_n) begin
			tally = '0;
			mean_acc = '0;
			var_acc = '0;
			stats_due_q.delete();
			mismatches = 0;
			words_seen = 0;
		end else begin
			// retire the older word first; a word accepted now belongs to an earlier sample
			if (out_valid && out_ready) begin
				got.count    = sample_count;
				got.mean     = running_mean;
				got.variance = running_variance;
				if (stats_due_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result word %0d: count %0d mean %0d variance %0d",
							words_seen, got.count, $signed(got.mean), $signed(got.variance));
					mismatches++;
				end else begin
					want = stats_due_q.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display({"word %0d mismatch: count exp %0d got %0d, ",
								"mean exp %0d got %0d, variance exp %0d got %0d"},
								words_seen, want.count, got.count,
								$signed(want.mean), $signed(got.mean),
								$signed(want.variance), $signed(got.variance));
						mismatches++;
					end
				end
				words_seen++;
			end
			if (in_valid && in_ready) begin
				fold_sample(sample, want);
				stats_due_q = {stats_due_q, want};
			end
		end
		errors    <= mismatches;
		words_due <= stats_due_q.size();
	end

endmodule

FILE: tb/tb_running_mean_variance_core.sv
// tb_running_mean_variance_core: drives samples into the core under several
// idle/stall patterns and gives the verdict from running_mean_variance_monitor.
// Depends on rmv_pkg, running_mean_variance_core and the monitor.
module tb_running_mean_variance_core;

	localparam int SAMPLE_W     = 32;
	localparam int COUNT_W      = 32;
	localparam int RANDOM_WORDS = 1700;
	localparam int PHASE_WORDS  = 212;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 3_000_000;

	typedef enum int {
		PH_STEADY,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [SAMPLE_W-1:0]                sample = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [rmv_pkg::OUT_W-1:0]          sample_count;
	logic signed [rmv_pkg::OUT_W-1:0]   running_mean;
	logic signed [rmv_pkg::WORD_W-1:0]  running_variance;
	int                                 errors;
	int                                 words_due;
	int                                 send_idle_pct = 0;
	int                                 stall_pct = 0;

	logic [SAMPLE_W-1:0] corner_samples[] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
		32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
		32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0003,
		32'hFFFF_FFFD, 32'h0000_0064, 32'hFFFF_FF9C, 32'h4000_0000,
		32'hC000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	running_mean_variance_core #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.COUNT_WIDTH (COUNT_W)
	) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_count    (sample_count),
		.running_mean    (running_mean),
		.running_variance(running_variance)
	);

	running_mean_variance_monitor #(
		.SAMPLE_WIDTH(SAMPLE_W),
		.COUNT_WIDTH (COUNT_W)
	) mon (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample          (sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.sample_count    (sample_count),
		.running_mean    (running_mean),
		.running_variance(running_variance),
		.errors          (errors),
		.words_due       (words_due)
	);

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	// called at a falling edge; returns at the falling edge after the word is taken
	task automatic send_word(input logic [SAMPLE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample   = v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("FAIL running_mean_variance_core");
		$finish;
	end

	initial begin
		logic [SAMPLE_W-1:0] center;
		logic [SAMPLE_W-1:0] v;
		int                  pick;
		phase_t              phase;
		center = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_samples[i]) send_word(corner_samples[i]);

		for (int idx = 0; idx < RANDOM_WORDS; idx++) begin
			if (idx % PHASE_WORDS == 0) begin
				phase = phase_t'((idx / PHASE_WORDS) % 4);
				case (phase)
					PH_STEADY: begin
						send_idle_pct = 0;
						stall_pct = 0;
					end
					PH_SEND_IDLE: begin
						send_idle_pct = 85;
						stall_pct = 0;
					end
					PH_RECV_STALL: begin
						send_idle_pct = 0;
						stall_pct = 85;
					end
					default: begin
						send_idle_pct = 18;
						stall_pct = 18;
					end
				endcase
			end
			// clustered values keep the variance meaningful; wide ones exercise wrapping
			if ($urandom_range(49) == 0)
				center = $urandom_range(1) ? $urandom() : 32'($signed(12'($urandom())));
			pick = $urandom_range(99);
			if (pick < 40)
				v = $urandom();
			else if (pick < 65)
				v = center + $urandom_range(200) - 32'd100;
			else if (pick < 90)
				v = 32'($signed(16'($urandom())));
			else begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0001;
				endcase
			end
			send_word(v);
		end
		in_valid = 1'b0;
		stall_pct = 0;

		while (words_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS running_mean_variance_core");
		else
			$display("FAIL running_mean_variance_core");
		$finish;
	end

endmodule
